[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define CAFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define CAFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked at every edge, reset included.
`define CAFU_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/cafu_pkg.sv]
// ----------------------------------------------------------------------------
// cafu_pkg
// Types and constants shared by the ALU and flag unit pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cafu_pkg;

	typedef enum logic [4:0] {
		CMD_ADD   = 5'd0,
		CMD_ADC   = 5'd1,
		CMD_SUB   = 5'd2,
		CMD_SBC   = 5'd3,
		CMD_AND   = 5'd4,
		CMD_XOR   = 5'd5,
		CMD_OR    = 5'd6,
		CMD_CP    = 5'd7,
		CMD_INC   = 5'd8,
		CMD_DEC   = 5'd9,
		CMD_RLCA  = 5'd10,
		CMD_RRCA  = 5'd11,
		CMD_RLA   = 5'd12,
		CMD_RRA   = 5'd13,
		CMD_DAA   = 5'd14,
		CMD_CPL   = 5'd15,
		CMD_SCF   = 5'd16,
		CMD_CCF   = 5'd17,
		CMD_ADD16 = 5'd18,
		CMD_SPOFS = 5'd19
	} cmd_e;

	localparam logic [7:0] ADJ_LOW       = 8'h06;
	localparam logic [7:0] ADJ_HIGH      = 8'h60;
	localparam logic [4:0] DAA_DIGIT_MAX = 5'd9;

	typedef struct packed {
		logic        z;
		logic        n;
		logic        h;
		logic        c;
	} flags_t;

	typedef struct packed {
		logic [4:0]  command;
		logic [7:0]  accumulator;
		logic [7:0]  operand;
		logic [15:0] wide_left;
		logic [15:0] wide_right;
		logic        zero_in;
		logic        subtract_in;
		logic        half_in;
		logic        carry_in;
	} in_t;

	typedef struct packed {
		logic [15:0] result;
		logic        zero_out;
		logic        subtract_out;
		logic        half_out;
		logic        carry_out;
	} out_t;

	// decoded beat: adder operands set up for the 8-bit and 16-bit paths
	typedef struct packed {
		cmd_e        cmd;
		logic [7:0]  a;
		logic [7:0]  v;
		logic [15:0] wl;
		logic [15:0] wr;
		flags_t      fl;
		logic [7:0]  opa;
		logic [7:0]  opb;
		logic        cin;
		logic [15:0] wopb;
	} dec_t;

	// executed beat: raw sums, partial carries, logic result and low-digit adjust
	typedef struct packed {
		cmd_e        cmd;
		logic [7:0]  a;
		flags_t      fl;
		logic [8:0]  sum8;
		logic        hc;
		logic [7:0]  logic_res;
		logic [16:0] wsum;
		logic        h12;
		logic        sp_h;
		logic        sp_c;
		logic [8:0]  daa_lo;
	} exe_t;

endpackage

[src/cafu_decode.sv]
// ----------------------------------------------------------------------------
// cafu_decode
// Stage 1: selects adder operands, inversion and carry-in per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cafu_decode import cafu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output dec_t out_data
);

	logic vld_s1;
	dec_t dec_s1;
	dec_t dec_d;
	cmd_e cmd;

	assign cmd      = cmd_e'(in_data.command);
	assign in_ready = !vld_s1 || out_ready;

	always_comb begin
		dec_d.cmd  = cmd;
		dec_d.a    = in_data.accumulator;
		dec_d.v    = in_data.operand;
		dec_d.wl   = in_data.wide_left;
		dec_d.wr   = in_data.wide_right;
		dec_d.fl   = '{z: in_data.zero_in, n: in_data.subtract_in,
			h: in_data.half_in, c: in_data.carry_in};
		dec_d.opa  = in_data.accumulator;
		dec_d.opb  = in_data.operand;
		dec_d.cin  = 1'b0;
		dec_d.wopb = (cmd == CMD_ADD16) ? in_data.wide_right
			: {{8{in_data.operand[7]}}, in_data.operand};
		// subtraction runs as a + ~b + ~borrow
		case (cmd)
			CMD_ADC: begin
				dec_d.cin = in_data.carry_in;
			end
			CMD_SUB, CMD_CP: begin
				dec_d.opb = ~in_data.operand;
				dec_d.cin = 1'b1;
			end
			CMD_SBC: begin
				dec_d.opb = ~in_data.operand;
				dec_d.cin = ~in_data.carry_in;
			end
			CMD_INC: begin
				dec_d.opa = in_data.operand;
				dec_d.opb = 8'h00;
				dec_d.cin = 1'b1;
			end
			CMD_DEC: begin
				dec_d.opa = in_data.operand;
				dec_d.opb = 8'hff;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= dec_d;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dec_s1;

endmodule

[src/cafu_exec.sv]
// ----------------------------------------------------------------------------
// cafu_exec
// Stage 2: 8-bit and 16-bit adders, logic ops, first decimal-adjust step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cafu_exec import cafu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dec_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output exe_t out_data
);

	logic       vld_s2;
	exe_t       exe_s2;
	exe_t       exe_d;
	logic [4:0] nib;
	logic [12:0] lo12;
	logic [4:0] sp_nib;
	logic [8:0] sp_byte;
	logic       adj_lo;

	assign in_ready = !vld_s2 || out_ready;

	assign nib     = {1'b0, in_data.opa[3:0]} + {1'b0, in_data.opb[3:0]}
		+ {4'b0, in_data.cin};
	assign lo12    = {1'b0, in_data.wl[11:0]} + {1'b0, in_data.wr[11:0]};
	assign sp_nib  = {1'b0, in_data.wl[3:0]} + {1'b0, in_data.v[3:0]};
	assign sp_byte = {1'b0, in_data.wl[7:0]} + {1'b0, in_data.v};
	assign adj_lo  = in_data.fl.h || ({1'b0, in_data.a[3:0]} > DAA_DIGIT_MAX);

	always_comb begin
		exe_d.cmd  = in_data.cmd;
		exe_d.a    = in_data.a;
		exe_d.fl   = in_data.fl;
		exe_d.sum8 = {1'b0, in_data.opa} + {1'b0, in_data.opb} + {8'b0, in_data.cin};
		exe_d.hc   = nib[4];
		exe_d.wsum = {1'b0, in_data.wl} + {1'b0, in_data.wopb};
		exe_d.h12  = lo12[12];
		exe_d.sp_h = sp_nib[4];
		exe_d.sp_c = sp_byte[8];
		case (in_data.cmd)
			CMD_AND: exe_d.logic_res = in_data.a & in_data.v;
			CMD_XOR: exe_d.logic_res = in_data.a ^ in_data.v;
			default: exe_d.logic_res = in_data.a | in_data.v;
		endcase
		// low-digit correction; borrow into the high byte never survives here
		if (in_data.fl.n) begin
			exe_d.daa_lo = {1'b0, in_data.a - (in_data.fl.h ? ADJ_LOW : 8'h00)};
		end else begin
			exe_d.daa_lo = {1'b0, in_data.a} + {1'b0, adj_lo ? ADJ_LOW : 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			exe_s2 <= exe_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = exe_s2;

endmodule

[src/cafu_flags.sv]
// ----------------------------------------------------------------------------
// cafu_flags
// Stage 3: result select, flag generation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cafu_flags import cafu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  exe_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic       vld_s3;
	out_t       rsp_s3;
	out_t       rsp_d;
	logic       adj_hi;
	logic [9:0] daa_t;
	logic       daa_c;
	logic [7:0] a;
	flags_t     fl;

	assign in_ready = !vld_s3 || out_ready;
	assign a        = in_data.a;
	assign fl       = in_data.fl;

	// high-digit correction of decimal adjust
	always_comb begin
		if (fl.n) begin
			adj_hi = fl.c;
			daa_t  = {2'b0, in_data.daa_lo[7:0] - (adj_hi ? ADJ_HIGH : 8'h00)};
			daa_c  = fl.c;
		end else begin
			adj_hi = fl.c || (in_data.daa_lo[8:4] > DAA_DIGIT_MAX);
			daa_t  = {1'b0, in_data.daa_lo} + {2'b0, adj_hi ? ADJ_HIGH : 8'h00};
			daa_c  = fl.c || (daa_t[9:8] != 2'b00);
		end
	end

	always_comb begin
		rsp_d.result       = {8'h00, a};
		rsp_d.zero_out     = fl.z;
		rsp_d.subtract_out = fl.n;
		rsp_d.half_out     = fl.h;
		rsp_d.carry_out    = fl.c;
		case (in_data.cmd)
			CMD_ADD, CMD_ADC: begin
				rsp_d.result       = {8'h00, in_data.sum8[7:0]};
				rsp_d.zero_out     = (in_data.sum8[7:0] == 8'h00);
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = in_data.hc;
				rsp_d.carry_out    = in_data.sum8[8];
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				if (in_data.cmd != CMD_CP) begin
					rsp_d.result = {8'h00, in_data.sum8[7:0]};
				end
				rsp_d.zero_out     = (in_data.sum8[7:0] == 8'h00);
				rsp_d.subtract_out = 1'b1;
				rsp_d.half_out     = !in_data.hc;
				rsp_d.carry_out    = !in_data.sum8[8];
			end
			CMD_AND, CMD_XOR, CMD_OR: begin
				rsp_d.result       = {8'h00, in_data.logic_res};
				rsp_d.zero_out     = (in_data.logic_res == 8'h00);
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = (in_data.cmd == CMD_AND);
				rsp_d.carry_out    = 1'b0;
			end
			CMD_INC, CMD_DEC: begin
				rsp_d.result       = {8'h00, in_data.sum8[7:0]};
				rsp_d.zero_out     = (in_data.sum8[7:0] == 8'h00);
				rsp_d.subtract_out = (in_data.cmd == CMD_DEC);
				rsp_d.half_out     = (in_data.cmd == CMD_DEC) ? !in_data.hc : in_data.hc;
			end
			CMD_RLCA: begin
				rsp_d.result       = {8'h00, a[6:0], a[7]};
				rsp_d.zero_out     = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = a[7];
			end
			CMD_RRCA: begin
				rsp_d.result       = {8'h00, a[0], a[7:1]};
				rsp_d.zero_out     = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = a[0];
			end
			CMD_RLA: begin
				rsp_d.result       = {8'h00, a[6:0], fl.c};
				rsp_d.zero_out     = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = a[7];
			end
			CMD_RRA: begin
				rsp_d.result       = {8'h00, fl.c, a[7:1]};
				rsp_d.zero_out     = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = a[0];
			end
			CMD_DAA: begin
				rsp_d.result    = {8'h00, daa_t[7:0]};
				rsp_d.zero_out  = (daa_t[7:0] == 8'h00);
				rsp_d.half_out  = 1'b0;
				rsp_d.carry_out = daa_c;
			end
			CMD_CPL: begin
				rsp_d.result       = {8'h00, ~a};
				rsp_d.subtract_out = 1'b1;
				rsp_d.half_out     = 1'b1;
			end
			CMD_SCF: begin
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = 1'b1;
			end
			CMD_CCF: begin
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = !fl.c;
			end
			CMD_ADD16: begin
				rsp_d.result       = in_data.wsum[15:0];
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = in_data.h12;
				rsp_d.carry_out    = in_data.wsum[16];
			end
			CMD_SPOFS: begin
				rsp_d.result       = in_data.wsum[15:0];
				rsp_d.zero_out     = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = in_data.sp_h;
				rsp_d.carry_out    = in_data.sp_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rsp_s3 <= rsp_d;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = rsp_s3;

endmodule

[src/cpu_alu_flag_unit_core.sv]
// ----------------------------------------------------------------------------
// cpu_alu_flag_unit_core
// ALU and flag unit of an 8-bit core as a three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                        | beat carries
//  req     | req_valid, req_ready, req      | command, operands, incoming flags
//  rsp     | rsp_valid, rsp_ready, rsp      | 16-bit result, outgoing flags
//
// Stages are decode, adders and the flag/result register; one beat per cycle
// is sustained while rsp_ready is high. The 16-bit adder is in the second stage.
// Reset clears the stage valid bits only; data registers are not reset.
// A stalled rsp holds every stage full; ready ripples back stage by stage,
// so a bubble anywhere is filled in the same cycle.
`timescale 1ns / 1ps

module cpu_alu_flag_unit_core import cafu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output out_t rsp
);

	logic dec_valid;
	logic dec_ready;
	dec_t dec_data;
	logic exe_valid;
	logic exe_ready;
	exe_t exe_data;

	cafu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_data   (req),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_data  (dec_data)
	);

	cafu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (exe_valid),
		.out_ready (exe_ready),
		.out_data  (exe_data)
	);

	cafu_flags u_flags (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exe_valid),
		.in_ready  (exe_ready),
		.in_data   (exe_data),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.out_data  (rsp)
	);

endmodule

[src/cafu_checker.sv]
// ----------------------------------------------------------------------------
// cafu_checker
// Port-level checks on the pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cafu_checker import cafu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input in_t  req,
	input logic rsp_valid,
	input logic rsp_ready,
	input out_t rsp
);

	`CAFU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")
	`CAFU_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp), "rsp payload changed while stalled")
	// an empty output stage means the whole pipe can move
	`CAFU_ASSERT_NOW(a_ready_empty, clk, arst_n, !rsp_valid, req_ready, "req stalled with empty output stage")
	`CAFU_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n, !rsp_valid, "rsp valid during reset")

endmodule

bind cpu_alu_flag_unit_core cafu_checker u_cafu_checker (.*);
